[src/fpbs_pkg.sv]
package fpbs_pkg;

	// Segment depth default
	localparam int ROW_DEPTH_DEF = 1024;

	// Field widths fixed by the item format
	localparam int VALUE_W    = 64;
	localparam int FIXED_W    = 63;
	localparam int ROW_W      = 10;
	localparam int COUNT_W    = 11;
	localparam int FRAC_W     = 6;
	localparam int PEXP_W     = 7;
	localparam int DB_W       = 6;
	localparam int PCOUNT_W   = 4;
	localparam int CFG_DATA_W = 7;

	// IEEE-754 double layout
	localparam int             EXP_W        = 11;
	localparam int             MANT_W       = 52;
	localparam logic [10:0]    EXP_ALL_ONES = 11'h7ff;
	localparam logic signed [11:0] EXP_BIAS = 12'sd1023;
	localparam logic signed [11:0] TOP_POS  = 12'sd63;
	localparam logic signed [11:0] SHIFT_LIMIT = 12'sd64;

	// Configuration register indexes
	localparam logic CFG_FRACTION_BITS = 1'b0;
	localparam logic CFG_EXP_FLOOR     = 1'b1;

	// Configuration reset values
	localparam logic [FRAC_W-1:0] FRACTION_BITS_RST = 6'd28;
	localparam logic [PEXP_W-1:0] EXP_FLOOR_RST     = 7'b1100100;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_FINISH = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_VALUE = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_ROW   = 3'd4
	} status_t;

	// Conversion result of one loaded value
	typedef struct packed {
		status_t              status;
		logic [FIXED_W-1:0]   fixed;
	} conv_t;

endpackage

[src/fpbs_convert.sv]
module fpbs_convert (
	input  logic [fpbs_pkg::VALUE_W-1:0] value_bits,
	input  logic [fpbs_pkg::FRAC_W-1:0]  fraction_bits,
	input  logic [fpbs_pkg::PEXP_W-1:0]  exp_floor,
	output fpbs_pkg::conv_t              conv
);

	logic [fpbs_pkg::EXP_W-1:0] exp_field;
	logic signed [11:0]         exponent;
	logic signed [11:0]         pexp;
	logic signed [11:0]         shift;
	logic [63:0]                sig;
	logic [63:0]                shifted;

	// Unpack the double and form the right shift that lands on the fraction point
	always_comb begin
		exp_field = value_bits[62 -: fpbs_pkg::EXP_W];
		exponent  = $signed({1'b0, exp_field}) - fpbs_pkg::EXP_BIAS;
		pexp      = 12'(signed'(exp_floor));
		shift     = fpbs_pkg::TOP_POS - exponent - $signed({6'b0, fraction_bits});
		sig       = {1'b1, value_bits[fpbs_pkg::MANT_W-1:0], 11'b0};
		shifted   = sig >> shift[5:0];
	end

	// Classify in priority order: zero, bad value, underflow, overflow, range
	always_comb begin
		conv.status = fpbs_pkg::ST_OK;
		conv.fixed  = '0;
		priority if (value_bits[62:0] == 63'd0) begin
			conv.status = fpbs_pkg::ST_OK;
		end else if (value_bits[63] || exp_field == fpbs_pkg::EXP_ALL_ONES) begin
			conv.status = fpbs_pkg::ST_BAD_VALUE;
		end else if (exponent < pexp) begin
			conv.status = fpbs_pkg::ST_OK;
		end else if (shift <= 12'sd0) begin
			conv.status = fpbs_pkg::ST_OVERFLOW;
		end else if (shift >= fpbs_pkg::SHIFT_LIMIT) begin
			conv.status = fpbs_pkg::ST_OK;
		end else begin
			conv.fixed = shifted[fpbs_pkg::FIXED_W-1:0];
		end
	end

endmodule

[src/fpbs_store.sv]
module fpbs_store #(
	parameter int DEPTH = fpbs_pkg::ROW_DEPTH_DEF,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [fpbs_pkg::FIXED_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [fpbs_pkg::FIXED_W-1:0] rdata
);

	logic [fpbs_pkg::FIXED_W-1:0] mem [DEPTH];

	// Write one row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/fpbs_range.sv]
module fpbs_range (
	input  logic                         clk,
	input  logic [fpbs_pkg::FIXED_W-1:0] hi_val,
	input  logic [fpbs_pkg::FIXED_W-1:0] lo_val,
	output logic [fpbs_pkg::DB_W-1:0]    delta_bits
);

	logic [fpbs_pkg::FIXED_W-1:0] range_q;
	logic [fpbs_pkg::DB_W-1:0]    db_q;
	logic [63:0] w64;
	logic [31:0] w32;
	logic [15:0] w16;
	logic [7:0]  w8;
	logic [3:0]  w4;
	logic [1:0]  w2;
	logic [5:0]  msb;

	// Subtract the extremes into a register once they settle
	always_ff @(posedge clk) begin
		range_q <= hi_val - lo_val;
	end

	// Find the top set bit by halving the word
	always_comb begin
		w64    = {1'b0, range_q};
		msb[5] = |w64[63:32];
		w32    = msb[5] ? w64[63:32] : w64[31:0];
		msb[4] = |w32[31:16];
		w16    = msb[4] ? w32[31:16] : w32[15:0];
		msb[3] = |w16[15:8];
		w8     = msb[3] ? w16[15:8] : w16[7:0];
		msb[2] = |w8[7:4];
		w4     = msb[2] ? w8[7:4] : w8[3:0];
		msb[1] = |w4[3:2];
		w2     = msb[1] ? w4[3:2] : w4[1:0];
		msb[0] = w2[1];
	end

	always_ff @(posedge clk) begin
		db_q <= (range_q == '0) ? '0 : msb + 6'd1;
	end

	assign delta_bits = db_q;

endmodule

[src/fpbs_planes.sv]
module fpbs_planes (
	input  logic [fpbs_pkg::FIXED_W-1:0] delta,
	input  logic [fpbs_pkg::DB_W-1:0]    delta_bits,
	output logic [63:0]                  planes
);

	logic [5:0]  lsh;
	logic [63:0] aligned;
	logic [2:0]  full;
	logic [2:0]  rem;
	logic [7:0]  rmask;

	// Left-align the delta so full planes come off the top a byte at a time
	always_comb begin
		lsh     = 6'(7'd64 - {1'b0, delta_bits});
		aligned = {1'b0, delta} << lsh;
		full    = delta_bits[5:3];
		rem     = delta_bits[2:0];
		rmask   = 8'((9'd1 << rem) - 9'd1);
	end

	// Place full planes first, then the low partial plane
	always_comb begin
		planes = '0;
		for (int p = 0; p < 8; p++) begin
			if (delta_bits == '0) begin
				planes[8*p +: 8] = 8'd0;
			end else if (4'(p) < {1'b0, full}) begin
				planes[8*p +: 8] = aligned[8*(7-p) +: 8];
			end else if (4'(p) == {1'b0, full} && rem != 3'd0) begin
				planes[8*p +: 8] = delta[7:0] & rmask;
			end
		end
	end

endmodule

[src/fp64_byteplane_segment_encoder_unit.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------------
// item     | item_valid / item_ready    | opcode, value_bits, row_index
// result   | result_valid / result_ready| status, row_total, seg_base, delta_bits,
//          |                            | plane_total, whole_bits, plane_bytes
// config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// One item per cycle while the result is taken and no finish waits; an item passes
// through the input stage and then the result register. After a successful load,
// a finish waits in the input stage until the range and bit width registers settle.
// A stalled result holds the input stage; a new item is still taken if the
// input stage is empty. Reset returns control state and configuration to their
// reset values; the row store has no reset and no clearing pass.
module fp64_byteplane_segment_encoder_unit #(
	parameter int ROW_DEPTH = fpbs_pkg::ROW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fpbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [1:0]                     opcode,
	input  logic [fpbs_pkg::VALUE_W-1:0]   value_bits,
	input  logic [fpbs_pkg::ROW_W-1:0]     row_index,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [2:0]                     status,
	output logic [fpbs_pkg::COUNT_W-1:0]   row_total,
	output logic [fpbs_pkg::FIXED_W-1:0]   seg_base,
	output logic [fpbs_pkg::DB_W-1:0]      delta_bits,
	output logic [fpbs_pkg::PCOUNT_W-1:0]  plane_total,
	output logic [fpbs_pkg::DB_W-1:0]      whole_bits,
	output logic [63:0]                    plane_bytes
);

	localparam int AW   = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int CW   = $clog2(ROW_DEPTH + 1);
	localparam int CMPW = (CW > fpbs_pkg::ROW_W) ? CW : fpbs_pkg::ROW_W;
	localparam logic [CW-1:0] ROWS_FULL = CW'(ROW_DEPTH);

	// Configuration
	logic [fpbs_pkg::FRAC_W-1:0] fraction_bits_q;
	logic [fpbs_pkg::PEXP_W-1:0] exp_floor_q;

	// Segment state
	logic [CW-1:0]                row_count_q;
	logic [fpbs_pkg::FIXED_W-1:0] min_q;
	logic [fpbs_pkg::FIXED_W-1:0] max_q;
	logic [1:0]                   sticky_q;
	logic                         finished_q;
	logic [1:0]                   pend_q;

	// Input stage
	logic                         valid_s1;
	fpbs_pkg::opcode_t            op_s1;
	logic [fpbs_pkg::ROW_W-1:0]   row_s1;
	fpbs_pkg::conv_t              conv_s1;
	logic [fpbs_pkg::FIXED_W-1:0] rdata_s1;

	// Result register
	logic                         res_valid_q;
	fpbs_pkg::status_t            status_q;
	logic [fpbs_pkg::COUNT_W-1:0] count_q;
	logic [fpbs_pkg::FIXED_W-1:0] base_q;
	logic [fpbs_pkg::DB_W-1:0]    db_out_q;
	logic [fpbs_pkg::PCOUNT_W-1:0] pcount_q;
	logic [fpbs_pkg::DB_W-1:0]    ibits_q;
	logic [63:0]                  planes_q;

	// Combinational
	fpbs_pkg::conv_t              conv_w;
	logic [fpbs_pkg::DB_W-1:0]    db_w;
	logic [fpbs_pkg::FIXED_W-1:0] delta_w;
	logic [63:0]                  planes_w;
	logic                         accept;
	logic                         adv;
	logic                         full;
	fpbs_pkg::status_t            load_status;
	logic                         load_ok;
	logic                         read_ok;
	fpbs_pkg::status_t            status_d;
	logic [CW-1:0]                count_d;
	logic [fpbs_pkg::FIXED_W-1:0] min_d;
	logic [fpbs_pkg::FIXED_W-1:0] max_d;
	logic [1:0]                   sticky_d;
	logic                         finished_d;
	logic [63:0]                  planes_d;
	logic                         show_summary;
	logic [6:0]                   db_round;

	// Convert at the port so the input stage holds a fixed-point value
	fpbs_convert u_convert (
		.value_bits    (value_bits),
		.fraction_bits (fraction_bits_q),
		.exp_floor     (exp_floor_q),
		.conv          (conv_w)
	);

	// Row store: write on a committed load, read as the item enters.
	// A read right behind a successful load always fails (finish is cleared),
	// so no write-to-read bypass is needed.
	fpbs_store #(
		.DEPTH (ROW_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (adv && load_ok),
		.waddr (AW'(row_count_q)),
		.wdata (conv_s1.fixed),
		.re    (accept),
		.raddr (AW'(row_index)),
		.rdata (rdata_s1)
	);

	fpbs_range u_range (
		.clk        (clk),
		.hi_val     (max_q),
		.lo_val     (min_q),
		.delta_bits (db_w)
	);

	assign delta_w = rdata_s1 - min_q;

	fpbs_planes u_planes (
		.delta      (delta_w),
		.delta_bits (db_w),
		.planes     (planes_w)
	);

	// Handshake: advance unless the result is blocked or a finish waits on the range
	assign adv = valid_s1 && (!res_valid_q || result_ready)
		&& !(op_s1 == fpbs_pkg::OP_FINISH && pend_q != 2'd0);
	assign item_ready = !valid_s1 || adv;
	assign accept     = item_valid && item_ready;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_bits_q <= fpbs_pkg::FRACTION_BITS_RST;
			exp_floor_q     <= fpbs_pkg::EXP_FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpbs_pkg::CFG_FRACTION_BITS: begin
					fraction_bits_q <= cfg_data[fpbs_pkg::FRAC_W-1:0];
				end
				fpbs_pkg::CFG_EXP_FLOOR: begin
					exp_floor_q <= cfg_data[fpbs_pkg::PEXP_W-1:0];
				end
			endcase
		end
	end

	// Capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= fpbs_pkg::opcode_t'(opcode);
			row_s1  <= row_index;
			conv_s1 <= conv_w;
		end
	end

	// Work out the next segment state and the result of the item in the stage
	always_comb begin
		full        = row_count_q >= ROWS_FULL;
		load_status = full ? fpbs_pkg::ST_FULL : conv_s1.status;
		load_ok     = (op_s1 == fpbs_pkg::OP_LOAD) && (load_status == fpbs_pkg::ST_OK);
		read_ok     = finished_q && (CMPW'(row_s1) < CMPW'(row_count_q));
		status_d    = fpbs_pkg::ST_OK;
		count_d     = row_count_q;
		min_d       = min_q;
		max_d       = max_q;
		sticky_d    = sticky_q;
		finished_d  = finished_q;
		planes_d    = '0;
		unique case (op_s1)
			fpbs_pkg::OP_LOAD: begin
				status_d = load_status;
				if (load_ok) begin
					count_d    = row_count_q + CW'(1);
					min_d      = (conv_s1.fixed < min_q) ? conv_s1.fixed : min_q;
					max_d      = (conv_s1.fixed > max_q) ? conv_s1.fixed : max_q;
					finished_d = 1'b0;
				end else if (sticky_q == 2'd0) begin
					sticky_d = load_status[1:0];
				end
			end
			fpbs_pkg::OP_FINISH: begin
				if (sticky_q != 2'd0) begin
					status_d   = fpbs_pkg::status_t'({1'b0, sticky_q});
					finished_d = 1'b0;
				end else begin
					finished_d = 1'b1;
				end
			end
			fpbs_pkg::OP_READ: begin
				if (read_ok) begin
					planes_d = planes_w;
				end else begin
					status_d = fpbs_pkg::ST_BAD_ROW;
				end
			end
			fpbs_pkg::OP_CLEAR: begin
				count_d    = '0;
				min_d      = '1;
				max_d      = '0;
				sticky_d   = 2'd0;
				finished_d = 1'b0;
			end
		endcase
		show_summary = finished_d && (count_d != '0);
		db_round     = {1'b0, db_w} + 7'd7;
	end

	// Commit segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sticky_q    <= 2'd0;
			finished_q  <= 1'b0;
		end else if (adv) begin
			row_count_q <= count_d;
			min_q       <= min_d;
			max_q       <= max_d;
			sticky_q    <= sticky_d;
			finished_q  <= finished_d;
		end
	end

	// Count down while the range and width registers catch up with a load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (adv && load_ok) begin
			pend_q <= 2'd2;
		end else if (pend_q != 2'd0) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			count_q  <= fpbs_pkg::COUNT_W'(count_d);
			planes_q <= planes_d;
			if (show_summary) begin
				base_q   <= min_q;
				db_out_q <= db_w;
				pcount_q <= db_round[6:3];
				ibits_q  <= (db_w > fraction_bits_q) ? db_w - fraction_bits_q : '0;
			end else begin
				base_q   <= '0;
				db_out_q <= '0;
				pcount_q <= '0;
				ibits_q  <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign row_total    = count_q;
	assign seg_base     = base_q;
	assign delta_bits   = db_out_q;
	assign plane_total  = pcount_q;
	assign whole_bits   = ibits_q;
	assign plane_bytes  = planes_q;

endmodule

[src/fpbs_checker.sv]
module fpbs_checker #(
	parameter int ROW_DEPTH = fpbs_pkg::ROW_DEPTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [2:0]                     status,
	input logic [fpbs_pkg::COUNT_W-1:0]   row_total,
	input logic [fpbs_pkg::FIXED_W-1:0]   seg_base,
	input logic [fpbs_pkg::DB_W-1:0]      delta_bits,
	input logic [fpbs_pkg::PCOUNT_W-1:0]  plane_total,
	input logic [fpbs_pkg::DB_W-1:0]      whole_bits,
	input logic [63:0]                    plane_bytes
);

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(status) && $stable(plane_bytes) && $stable(row_total))
		else $error("result changed while stalled");

	// Planes only come with a successful read
	a_planes_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && plane_bytes != 64'd0 |-> status == 3'(fpbs_pkg::ST_OK))
		else $error("plane bytes on a failed item");

	// An empty segment shows no summary
	a_empty_summary: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && row_total == '0 |->
			seg_base == '0 && delta_bits == '0 && plane_total == '0 && whole_bits == '0)
		else $error("summary on an empty segment");

	// Row count stays within the store, integer bits within the width and planes at most eight
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(row_total) <= ROW_DEPTH && whole_bits <= delta_bits
			&& plane_total <= 4'd8)
		else $error("count or summary out of bounds");

endmodule

bind fp64_byteplane_segment_encoder_unit fpbs_checker #(
	.ROW_DEPTH (ROW_DEPTH)
) u_fpbs_checker (.*);
